// ----- src/rrps_pkg.sv -----
// Shared types and constants for the round-robin process scheduler.
package rrps_pkg;

    localparam int ENTRIES_DEF = 8;

    localparam logic [7:0] TIME_SLICE_RST = 8'd16;

    // Entry state encoding
    localparam logic [1:0] ST_DEAD     = 2'd0;
    localparam logic [1:0] ST_RUNNABLE = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_BLOCKED  = 2'd3;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_FORK  = 2'd1;
    localparam logic [1:0] OP_SLEEP = 2'd2;
    localparam logic [1:0] OP_EXIT  = 2'd3;

    // Table write kinds issued by the controller
    localparam logic [2:0] WR_NONE   = 3'd0;
    localparam logic [2:0] WR_TDEC   = 3'd1;
    localparam logic [2:0] WR_TSLICE = 3'd2;
    localparam logic [2:0] WR_SLEEP  = 3'd3;
    localparam logic [2:0] WR_EXIT   = 3'd4;
    localparam logic [2:0] WR_FORK   = 3'd5;
    localparam logic [2:0] WR_RUN    = 3'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] sleep_ticks;
    } req_t;

    typedef struct packed {
        logic [2:0] running_entry;
        logic       switched;
        logic       fork_ok;
        logic [2:0] child_entry;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] sleep_count;
        logic [7:0]  slice_count;
    } ent_t;

    typedef struct packed {
        logic       load_req;
        logic       rd_en;
        logic       walk_zero;
        logic       walk_to_cur;
        logic       walk_cur_next;
        logic       walk_inc;
        logic [2:0] wr_op;
        logic       out_load;
    } ctl_t;

    typedef struct packed {
        logic [1:0] req_op;
        logic [1:0] op;
        logic [1:0] rd_state;
        logic       walk_last;
        logic       walk_is_cur;
        logic       slice_expire;
        logic       out_free;
    } sts_t;

endpackage

// ----- src/round_robin_process_scheduler_core.sv -----
// Top level of the round-robin process scheduler: controller plus datapath.
// One request (tick, fork, sleep or exit) is handled at a time; the table is held in a
// single-port memory and walked one entry at a time (read, then check and write back).
// A fork scans from entry 0 for a dead entry; sleep and exit update the current entry,
// then search onward for the next runnable one; a tick walks the whole table, then
// updates the current entry's slice and searches onward when the slice expires.
// The block returns to idle, ready for the next request, in the cycle after the result is
// loaded; the result register frees the next request to be taken while a result still
// waits. time_slice resets to 16 and is written through cfg_we/cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
module round_robin_process_scheduler_core
#(
    parameter int ENTRIES = rrps_pkg::ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  rrps_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rrps_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata
);

    rrps_pkg::ctl_t ctl;
    rrps_pkg::sts_t sts;

    rrps_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    rrps_datapath
    #(
        .ENTRIES (ENTRIES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- src/rrps_ctrl.sv -----
// Sequencing state machine for the scheduler: walks the table one entry at a time.
module rrps_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rrps_pkg::sts_t     sts,
    output rrps_pkg::ctl_t     ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TW_RD   = 4'd1;
    localparam logic [3:0] S_TW_CHK  = 4'd2;
    localparam logic [3:0] S_TC_RD   = 4'd3;
    localparam logic [3:0] S_TC_CHK  = 4'd4;
    localparam logic [3:0] S_CUR_RD  = 4'd5;
    localparam logic [3:0] S_CUR_CHK = 4'd6;
    localparam logic [3:0] S_FK_RD   = 4'd7;
    localparam logic [3:0] S_FK_CHK  = 4'd8;
    localparam logic [3:0] S_SR_RD   = 4'd9;
    localparam logic [3:0] S_SR_CHK  = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.wr_op  = rrps_pkg::WR_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load_req = 1'b1;
                    unique case (sts.req_op)
                        rrps_pkg::OP_TICK:
                        begin
                            ctl.walk_zero = 1'b1;
                            state_next    = S_TW_RD;
                        end
                        rrps_pkg::OP_FORK:
                        begin
                            ctl.walk_zero = 1'b1;
                            state_next    = S_FK_RD;
                        end
                        default:
                        begin
                            ctl.walk_to_cur = 1'b1;
                            state_next      = S_CUR_RD;
                        end
                    endcase
                end
            end
            S_TW_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_TW_CHK;
            end
            S_TW_CHK:
            begin
                ctl.wr_op = rrps_pkg::WR_TDEC;
                if (sts.walk_last)
                begin
                    ctl.walk_to_cur = 1'b1;
                    state_next      = S_TC_RD;
                end
                else
                begin
                    ctl.walk_inc = 1'b1;
                    state_next   = S_TW_RD;
                end
            end
            S_TC_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_TC_CHK;
            end
            S_TC_CHK:
            begin
                ctl.wr_op = rrps_pkg::WR_TSLICE;
                if (sts.slice_expire)
                begin
                    ctl.walk_cur_next = 1'b1;
                    state_next        = S_SR_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CUR_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_CUR_CHK;
            end
            S_CUR_CHK:
            begin
                ctl.wr_op = (sts.op == rrps_pkg::OP_SLEEP) ? rrps_pkg::WR_SLEEP
                                                           : rrps_pkg::WR_EXIT;
                ctl.walk_cur_next = 1'b1;
                state_next        = S_SR_RD;
            end
            S_FK_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_FK_CHK;
            end
            S_FK_CHK:
            begin
                priority if (sts.rd_state == rrps_pkg::ST_DEAD)
                begin
                    ctl.wr_op  = rrps_pkg::WR_FORK;
                    state_next = S_DONE;
                end
                else if (sts.walk_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.walk_inc = 1'b1;
                    state_next   = S_FK_RD;
                end
            end
            S_SR_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_SR_CHK;
            end
            S_SR_CHK:
            begin
                // falls back to the current entry when nothing else is runnable
                if (sts.rd_state == rrps_pkg::ST_RUNNABLE || sts.walk_is_cur)
                begin
                    ctl.wr_op  = rrps_pkg::WR_RUN;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.walk_inc = 1'b1;
                    state_next   = S_SR_RD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rrps_datapath.sv -----
// Process table memory, walk index, current entry and result register.
module rrps_datapath
#(
    parameter int ENTRIES = rrps_pkg::ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rrps_pkg::req_t     req,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  rrps_pkg::ctl_t     ctl,
    output rrps_pkg::sts_t     sts,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rrps_pkg::rsp_t     rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    rrps_pkg::ent_t mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    rrps_pkg::ent_t   rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_first_reg;
    rrps_pkg::ent_t   rd_ent;

    logic [IDX_W-1:0] walk_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] before_reg;
    logic [IDX_W-1:0] child_reg;
    logic             fork_ok_reg;
    logic [1:0]       op_reg;
    logic [15:0]      ticks_reg;
    logic [7:0]       time_slice_reg;

    logic             rsp_valid_reg;
    rrps_pkg::rsp_t   rsp_reg;
    rrps_pkg::rsp_t   rsp_next;

    logic [IDX_W-1:0] walk_succ;
    logic [IDX_W-1:0] cur_succ;
    logic [7:0]       slice_inc;
    logic             expire;
    logic             wr_en;
    rrps_pkg::ent_t   wr_data;
    logic [IDX_W+2:0] cur_ext;
    logic [IDX_W+2:0] child_ext;

    assign walk_succ = (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;
    assign cur_succ  = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;

    // Entries never written read as their reset contents
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_ent = rd_data_reg;
        end
        else
        begin
            rd_ent.state       = rd_first_reg ? rrps_pkg::ST_RUNNING : rrps_pkg::ST_DEAD;
            rd_ent.sleep_count = '0;
            rd_ent.slice_count = '0;
        end
    end

    assign slice_inc = (rd_ent.slice_count == 8'hFF) ? 8'hFF : rd_ent.slice_count + 8'd1;
    assign expire    = (slice_inc >= time_slice_reg);

    always_comb
    begin
        wr_en   = 1'b1;
        wr_data = rd_ent;
        unique case (ctl.wr_op)
            rrps_pkg::WR_TDEC:
            begin
                wr_en = (rd_ent.state == rrps_pkg::ST_BLOCKED);
                if (rd_ent.sleep_count <= 16'd1)
                begin
                    wr_data.state       = rrps_pkg::ST_RUNNABLE;
                    wr_data.sleep_count = '0;
                end
                else
                begin
                    wr_data.sleep_count = rd_ent.sleep_count - 16'd1;
                end
            end
            rrps_pkg::WR_TSLICE:
            begin
                if (expire)
                begin
                    wr_data.state       = rrps_pkg::ST_RUNNABLE;
                    wr_data.slice_count = '0;
                end
                else
                begin
                    wr_data.slice_count = slice_inc;
                end
            end
            rrps_pkg::WR_SLEEP:
            begin
                wr_data.state       = rrps_pkg::ST_BLOCKED;
                wr_data.sleep_count = (ticks_reg == '0) ? 16'd1 : ticks_reg;
            end
            rrps_pkg::WR_EXIT:
            begin
                wr_data.state = rrps_pkg::ST_DEAD;
            end
            rrps_pkg::WR_FORK:
            begin
                wr_data.state       = rrps_pkg::ST_RUNNABLE;
                wr_data.sleep_count = '0;
                wr_data.slice_count = '0;
            end
            rrps_pkg::WR_RUN:
            begin
                wr_data.state = rrps_pkg::ST_RUNNING;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Table memory: one read and one write port, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[walk_reg] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[walk_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[walk_reg] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[walk_reg];
                rd_first_reg <= (walk_reg == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= '0;
            cur_reg        <= '0;
            before_reg     <= '0;
            child_reg      <= '0;
            fork_ok_reg    <= 1'b0;
            op_reg         <= rrps_pkg::OP_TICK;
            ticks_reg      <= '0;
            time_slice_reg <= rrps_pkg::TIME_SLICE_RST;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                time_slice_reg <= cfg_wdata;
            end
            if (ctl.load_req)
            begin
                op_reg      <= req.operation;
                ticks_reg   <= req.sleep_ticks;
                before_reg  <= cur_reg;
                fork_ok_reg <= 1'b0;
                child_reg   <= '0;
            end
            priority if (ctl.walk_zero)
            begin
                walk_reg <= '0;
            end
            else if (ctl.walk_to_cur)
            begin
                walk_reg <= cur_reg;
            end
            else if (ctl.walk_cur_next)
            begin
                walk_reg <= cur_succ;
            end
            else if (ctl.walk_inc)
            begin
                walk_reg <= walk_succ;
            end
            if (ctl.wr_op == rrps_pkg::WR_FORK)
            begin
                fork_ok_reg <= 1'b1;
                child_reg   <= walk_reg;
            end
            if (ctl.wr_op == rrps_pkg::WR_RUN)
            begin
                cur_reg <= walk_reg;
            end
            if (ctl.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign cur_ext   = {3'b000, cur_reg};
    assign child_ext = {3'b000, child_reg};

    always_comb
    begin
        rsp_next.running_entry = cur_ext[2:0];
        rsp_next.switched      = (cur_reg != before_reg);
        rsp_next.fork_ok       = fork_ok_reg;
        rsp_next.child_entry   = child_ext[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        sts.req_op       = req.operation;
        sts.op           = op_reg;
        sts.rd_state     = rd_ent.state;
        sts.walk_last    = (walk_reg == LAST_IDX);
        sts.walk_is_cur  = (walk_reg == cur_reg);
        sts.slice_expire = expire;
        sts.out_free     = !rsp_valid_reg || rsp_ready;
    end

    // The current entry moves only when the search commits a new running entry
    a_cur_moves_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cur_reg) |-> $past(ctl.wr_op == rrps_pkg::WR_RUN))
        else $error("current entry changed outside a switch");

    a_slice_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(time_slice_reg) |-> $past(cfg_we))
        else $error("time slice changed without a configuration write");

    a_child_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !fork_ok_reg |-> (child_reg == '0))
        else $error("child index set without a successful fork");

    a_no_load_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

endmodule

// ----- dv/tb_round_robin_process_scheduler_core.sv -----
// Self-checking testbench for the round-robin process scheduler core.
`timescale 1ns / 1ps

module tb_round_robin_process_scheduler_core;

    localparam int N           = rrps_pkg::ENTRIES_DEF;
    localparam int SETTLE      = 40;    // margin after draining, covers the longest request including a switch
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_OPS   = 250;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    rrps_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    rrps_pkg::rsp_t rsp;
    logic           cfg_we    = 1'b0;
    logic [7:0]     cfg_wdata = '0;

    // process table as the testbench sees it
    logic [1:0]  ent_st    [N];
    logic [15:0] ent_sleep [N];
    logic [7:0]  ent_slice [N];
    int          cur_ent;
    logic [7:0]  slice_limit;

    rrps_pkg::req_t ops_to_send[$];
    rrps_pkg::rsp_t outcomes_due[$];
    int   mismatches  = 0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   quiet_cycles = 0;
    bit   idle_on     = 1'b0;

    round_robin_process_scheduler_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round-robin hand-over: first runnable entry after the current one, else itself.
    function automatic void hand_over();
        int i;
        i = (cur_ent + 1) % N;
        while (i != cur_ent && ent_st[i] != rrps_pkg::ST_RUNNABLE)
            i = (i + 1) % N;
        cur_ent = i;
        ent_st[i] = rrps_pkg::ST_RUNNING;
    endfunction

    function automatic rrps_pkg::rsp_t schedule_op(rrps_pkg::req_t r);
        rrps_pkg::rsp_t o;
        int   prev_ent;
        o = '0;
        prev_ent = cur_ent;
        case (r.operation)
            rrps_pkg::OP_TICK:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (ent_st[i] == rrps_pkg::ST_BLOCKED)
                    begin
                        if (ent_sleep[i] <= 16'd1)
                        begin
                            ent_sleep[i] = '0;
                            ent_st[i] = rrps_pkg::ST_RUNNABLE;
                        end
                        else
                            ent_sleep[i] = ent_sleep[i] - 16'd1;
                    end
                end
                if (ent_slice[cur_ent] != 8'hFF)
                    ent_slice[cur_ent] = ent_slice[cur_ent] + 8'd1;
                if (ent_slice[cur_ent] >= slice_limit)
                begin
                    ent_slice[cur_ent] = '0;
                    ent_st[cur_ent] = rrps_pkg::ST_RUNNABLE;
                    hand_over();
                end
            end
            rrps_pkg::OP_FORK:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (!o.fork_ok && ent_st[i] == rrps_pkg::ST_DEAD)
                    begin
                        ent_st[i] = rrps_pkg::ST_RUNNABLE;
                        ent_sleep[i] = '0;
                        ent_slice[i] = '0;
                        o.fork_ok = 1'b1;
                        o.child_entry = 3'(i);
                    end
                end
            end
            rrps_pkg::OP_SLEEP:
            begin
                ent_st[cur_ent] = rrps_pkg::ST_BLOCKED;
                ent_sleep[cur_ent] = (r.sleep_ticks == 16'd0) ? 16'd1 : r.sleep_ticks;
                hand_over();
            end
            default:
            begin
                ent_st[cur_ent] = rrps_pkg::ST_DEAD;
                hand_over();
            end
        endcase
        o.running_entry = 3'(cur_ent);
        o.switched = (cur_ent != prev_ent);
        return o;
    endfunction

    function automatic rrps_pkg::req_t make_op(logic [1:0] op, logic [15:0] ticks);
        rrps_pkg::req_t r;
        r.operation = op;
        r.sleep_ticks = ticks;
        return r;
    endfunction

    // Ticks most often; sleeps kept short so entries wake again unless long ones are allowed.
    function automatic rrps_pkg::req_t random_op(bit allow_long);
        rrps_pkg::req_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        r.sleep_ticks = 16'($urandom);
        if (roll < 45)
            r.operation = rrps_pkg::OP_TICK;
        else if (roll < 65)
            r.operation = rrps_pkg::OP_FORK;
        else if (roll < 85)
        begin
            r.operation = rrps_pkg::OP_SLEEP;
            if (!(allow_long && $urandom_range(0, 19) == 0))
                r.sleep_ticks = 16'($urandom_range(0, 12));
        end
        else
            r.operation = rrps_pkg::OP_EXIT;
        return r;
    endfunction

    function automatic int hold_len();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                outcomes_due.push_back(schedule_op(req));
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (ops_to_send.size() > 0)
                begin
                    req <= ops_to_send.pop_front();
                    req_valid <= 1'b1;
                    send_gap = hold_len();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk)
    begin : mon
        rrps_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    check_field("running_entry", want.running_entry, rsp.running_entry);
                    check_field("switched", want.switched, rsp.switched);
                    check_field("fork_ok", want.fork_ok, rsp.fork_ok);
                    check_field("child_entry", want.child_entry, rsp.child_entry);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall_left = hold_len();
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("** round_robin_process_scheduler_core: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (ops_to_send.size() != 0 || req_valid || outcomes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_slice(input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        slice_limit = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] slices [6];
        for (int i = 0; i < N; i++)
        begin
            ent_st[i] = rrps_pkg::ST_DEAD;
            ent_sleep[i] = '0;
            ent_slice[i] = '0;
        end
        ent_st[0] = rrps_pkg::ST_RUNNING;
        cur_ent = 0;
        slice_limit = rrps_pkg::TIME_SLICE_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: lone entry falls back to itself, table fills, fork fails, reuse
        ops_to_send.push_back(make_op(rrps_pkg::OP_TICK, 16'h0000));
        ops_to_send.push_back(make_op(rrps_pkg::OP_EXIT, 16'hFFFF));
        ops_to_send.push_back(make_op(rrps_pkg::OP_SLEEP, 16'h0000));
        for (int i = 0; i < N; i++)
            ops_to_send.push_back(make_op(rrps_pkg::OP_FORK, 16'h0000));
        ops_to_send.push_back(make_op(rrps_pkg::OP_SLEEP, 16'h0000));
        ops_to_send.push_back(make_op(rrps_pkg::OP_TICK, 16'h0000));
        ops_to_send.push_back(make_op(rrps_pkg::OP_SLEEP, 16'h0002));
        ops_to_send.push_back(make_op(rrps_pkg::OP_SLEEP, 16'h0001));
        ops_to_send.push_back(make_op(rrps_pkg::OP_EXIT, 16'h0000));
        ops_to_send.push_back(make_op(rrps_pkg::OP_EXIT, 16'h0000));
        ops_to_send.push_back(make_op(rrps_pkg::OP_FORK, 16'hFFFF));
        ops_to_send.push_back(make_op(rrps_pkg::OP_TICK, 16'hFFFF));
        ops_to_send.push_back(make_op(rrps_pkg::OP_TICK, 16'h0000));
        ops_to_send.push_back(make_op(rrps_pkg::OP_TICK, 16'h0000));
        wait_drained();

        idle_on = 1'b1;
        repeat (PHASE_OPS) ops_to_send.push_back(random_op(1'b0));
        wait_drained();

        slices[0] = 8'd1;
        slices[1] = 8'd255;
        slices[2] = 8'd2;
        slices[3] = 8'd4;
        slices[4] = 8'($urandom_range(1, 255));
        slices[5] = 8'($urandom_range(1, 255));
        for (int p = 0; p < 6; p++)
        begin
            write_slice(slices[p]);
            idle_on = (p != 2) && ($urandom_range(0, 3) != 0);
            // long sleeps park entries for good, so only in the last phase
            if (p == 5)
            begin
                ops_to_send.push_back(make_op(rrps_pkg::OP_SLEEP, 16'hFFFF));
                ops_to_send.push_back(make_op(rrps_pkg::OP_SLEEP, 16'h8000));
            end
            repeat (PHASE_OPS) ops_to_send.push_back(random_op(p == 5));
            wait_drained();
        end

        if (mismatches == 0 && outcomes_due.size() == 0)
            $display("** round_robin_process_scheduler_core: PASSED **");
        else
            $display("** round_robin_process_scheduler_core: FAILED **");
        $finish;
    end

endmodule
